>>> hdl/mlca_pkg.sv
// shared types and constants of the multilabel confusion accumulator
`default_nettype none

package mlca_pkg;

    // fixed field widths
    localparam int MASK_WIDTH = 8;
    localparam int COUNT_W    = 32;
    localparam int IDX_W      = 3;
    localparam int KIND_W     = 2;

    // cells of the full mask grid, row-major with MASK_WIDTH columns
    localparam int GRID_CELLS = MASK_WIDTH * MASK_WIDTH;
    localparam int GRID_IDX_W = $clog2(GRID_CELLS);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ACC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        OP_ACC,
        OP_READ,
        OP_CLEAR
    } mlca_op_t;

    typedef struct packed {
        mlca_op_t                op;
        logic [GRID_CELLS-1:0]   hit;      // cells to bump on accumulate
        logic [GRID_IDX_W-1:0]   rd_idx;   // row * MASK_WIDTH + col
        logic                    rd_ok;    // read address inside the matrix
    } mlca_cmd_t;

    typedef struct packed {
        logic              valid;
        logic              full;
        logic [QCNT_W-1:0] count;
    } mlca_q_status_t;

endpackage

`default_nettype wire

>>> hdl/multilabel_confusion_accumulator.sv
// top level of the multilabel confusion accumulator
`default_nettype none

// Builds a NUM_CLASSES x NUM_CLASSES multi-label confusion matrix of 32-bit
// saturating counters (row = true class, column = predicted class). A request
// of kind accumulate bumps every counter (i, j) with label i and response j set
// where i == j or label j is clear; kind read returns one counter on the result
// channel (zero when the row or column is out of range); kind clear zeroes the
// matrix; kind 3 is dropped. Only accepted read requests give a result, in
// request order. Throughput is one request per cycle while the command queue
// has room: all increments of a sample happen in parallel in the counter bank.
// A read result is registered: the front decodes an accepted request into the
// two-entry command queue at the accepting edge, and the counter bank pops it
// once it heads the queue and the output register is free, and its read lands
// in the output register. Requests keep flowing while a result waits to be
// taken; req_ready falls only once both queue entries are held behind a
// stalled read. Classes at or above the 8-bit mask width never count, so only
// min(NUM_CLASSES, 8) squared counters are built. Counters reset to zero.

module multilabel_confusion_accumulator
    import mlca_pkg::*;
#(
    parameter int NUM_CLASSES = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire logic [KIND_W-1:0]     kind,
    input  wire logic [MASK_WIDTH-1:0] label_mask,
    input  wire logic [MASK_WIDTH-1:0] response_mask,
    input  wire logic [IDX_W-1:0]      read_row,
    input  wire logic [IDX_W-1:0]      read_col,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output logic [COUNT_W-1:0]         count_value
);

    logic           req_fire;
    logic           q_push;
    logic           q_pop;
    mlca_cmd_t      front_cmd;
    mlca_cmd_t      head_cmd;
    mlca_q_status_t q_status;

    // queue room is the only thing that holds off a request
    assign req_ready = !q_status.full;
    assign req_fire  = req_valid && req_ready;

    // decode kind and build the per-cell increment mask
    mlca_front #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_front (
        .req_fire      (req_fire),
        .kind          (kind),
        .label_mask    (label_mask),
        .response_mask (response_mask),
        .read_row      (read_row),
        .read_col      (read_col),
        .push          (q_push),
        .cmd           (front_cmd)
    );

    // lets the front keep taking requests while the back waits on a result
    mlca_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    // counter bank and output register
    mlca_back #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_status.valid),
        .cmd         (head_cmd),
        .pop         (q_pop),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .count_value (count_value)
    );

    // undefined kind never reaches the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (kind != KIND_ACC) && (kind != KIND_READ) && (kind != KIND_CLEAR))
            |-> !q_push)
    else $error("undefined request kind entered the queue");

    // a popped read always shows up as a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && (head_cmd.op == OP_READ)) |=> res_valid)
    else $error("read popped without a result");

    // queue occupancy stays within its depth and the back only pops what exists
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(q_status.count) <= QUEUE_DEPTH) && (!q_pop || q_status.valid))
    else $error("command queue overrun or underrun");

endmodule

`default_nettype wire

>>> hdl/mlca_front.sv
// front end: decodes a request into a counter-bank command
`default_nettype none

module mlca_front
    import mlca_pkg::*;
#(
    parameter int NUM_CLASSES = 8
) (
    input  wire logic                  req_fire,
    input  wire logic [KIND_W-1:0]     kind,
    input  wire logic [MASK_WIDTH-1:0] label_mask,
    input  wire logic [MASK_WIDTH-1:0] response_mask,
    input  wire logic [IDX_W-1:0]      read_row,
    input  wire logic [IDX_W-1:0]      read_col,
    output logic                       push,
    output mlca_cmd_t                  cmd
);

    localparam int ACTIVE = (NUM_CLASSES < MASK_WIDTH) ? NUM_CLASSES : MASK_WIDTH;

    logic [GRID_CELLS-1:0] hit;

    // label i with response j, unless j is also a true label off the diagonal
    for (genvar g = 0; g < GRID_CELLS; g++) begin : g_hit
        localparam int R = g / MASK_WIDTH;
        localparam int C = g % MASK_WIDTH;
        if (R < ACTIVE && C < ACTIVE) begin : g_live
            if (R == C) begin : g_diag
                assign hit[g] = label_mask[R] & response_mask[C];
            end else begin : g_off
                assign hit[g] = label_mask[R] & response_mask[C] & ~label_mask[C];
            end
        end else begin : g_dead
            assign hit[g] = 1'b0;
        end
    end

    always_comb
    begin
        cmd.hit    = hit;
        cmd.rd_idx = {read_row, read_col};
        cmd.rd_ok  = (32'(read_row) < NUM_CLASSES) && (32'(read_col) < NUM_CLASSES);
        cmd.op     = OP_ACC;
        push       = 1'b0;
        unique case (kind)
            KIND_ACC:
            begin
                cmd.op = OP_ACC;
                push   = req_fire;
            end
            KIND_READ:
            begin
                cmd.op = OP_READ;
                push   = req_fire;
            end
            KIND_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                push   = req_fire;
            end
            default:
            begin
                // undefined kind is dropped
                cmd.op = OP_ACC;
                push   = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/mlca_queue.sv
// short command queue between front and back
`default_nettype none

module mlca_queue
    import mlca_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  mlca_cmd_t  push_cmd,
    input  wire logic  pop,
    output mlca_cmd_t  head_cmd,
    output mlca_q_status_t status
);

    mlca_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] n;
        n = (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + QPTR_W'(1);
        return n;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd     = entry_reg[rd_ptr_reg];
    assign status.valid = (count_reg != '0);
    assign status.full  = (32'(count_reg) == QUEUE_DEPTH);
    assign status.count = count_reg;

endmodule

`default_nettype wire

>>> hdl/mlca_back.sv
// back end: saturating counter bank and registered read result
`default_nettype none

module mlca_back
    import mlca_pkg::*;
#(
    parameter int NUM_CLASSES = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  mlca_cmd_t               cmd,
    output logic                    pop,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output logic [COUNT_W-1:0]      count_value
);

    localparam int ACTIVE = (NUM_CLASSES < MASK_WIDTH) ? NUM_CLASSES : MASK_WIDTH;

    logic [COUNT_W-1:0] grid [GRID_CELLS];
    logic               res_valid_reg;
    logic [COUNT_W-1:0] count_value_reg;
    logic               do_acc;
    logic               do_clear;
    logic               do_read;

    // a read waits only while an untaken result holds the output register
    assign pop      = cmd_valid && ((cmd.op != OP_READ) || !res_valid_reg || res_ready);
    assign do_acc   = pop && (cmd.op == OP_ACC);
    assign do_clear = pop && (cmd.op == OP_CLEAR);
    assign do_read  = pop && (cmd.op == OP_READ);

    // one saturating counter per live class pair; classes past the masks stay zero
    for (genvar g = 0; g < GRID_CELLS; g++) begin : g_cell
        localparam int R = g / MASK_WIDTH;
        localparam int C = g % MASK_WIDTH;
        if (R < ACTIVE && C < ACTIVE) begin : g_live
            logic [COUNT_W-1:0] cnt_reg;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cnt_reg <= '0;
                end
                else if (do_clear)
                begin
                    cnt_reg <= '0;
                end
                else if (do_acc && cmd.hit[g] && (cnt_reg != '1))
                begin
                    cnt_reg <= cnt_reg + COUNT_W'(1);
                end
            end
            assign grid[g] = cnt_reg;
        end else begin : g_dead
            assign grid[g] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (do_read)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_read)
        begin
            count_value_reg <= cmd.rd_ok ? grid[cmd.rd_idx] : '0;
        end
    end

    assign res_valid   = res_valid_reg;
    assign count_value = count_value_reg;

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the multilabel confusion accumulator

module tb;
    import mlca_pkg::*;

    localparam int CLASSES     = 8;
    localparam int CELLS       = CLASSES * CLASSES;
    localparam int MAX_SHOWN   = 10;
    localparam int RANDOM_REQS = 1150;
    localparam int HOLD_START  = 300;   // requests accepted before the long result stall
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE      = 20;    // cycles waited after the last result

    // the one kind code the block drops without a trace
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    // one request as the sender sees it, with its idle gap and drain flag
    typedef struct {
        logic [KIND_W-1:0]     kind;
        logic [MASK_WIDTH-1:0] labels;
        logic [MASK_WIDTH-1:0] preds;
        logic [IDX_W-1:0]      row;
        logic [IDX_W-1:0]      col;
        int                    gap;     // idle cycles before the request is offered
        bit                    drain;   // wait until every read is answered first
    } sample_req_t;

    // ports of the block
    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  req_valid     = 1'b0;
    logic                  req_ready;
    logic [KIND_W-1:0]     kind          = KIND_ACC;
    logic [MASK_WIDTH-1:0] label_mask    = '0;
    logic [MASK_WIDTH-1:0] response_mask = '0;
    logic [IDX_W-1:0]      read_row      = '0;
    logic [IDX_W-1:0]      read_col      = '0;
    logic                  res_valid;
    logic                  res_ready     = 1'b0;
    logic [COUNT_W-1:0]    count_value;

    // requests waiting to be driven, and the one on the bus right now
    sample_req_t        pending_reqs[$];
    sample_req_t        on_bus;
    // count values that accepted reads must return, oldest first
    logic [COUNT_W-1:0] expected_counts[$];
    // our own copy of the confusion matrix, row-major
    logic [COUNT_W-1:0] conf_model[CELLS];

    // handshake flags taken at the rising edge, read at the falling edge
    bit req_taken = 1'b0;
    bit res_taken = 1'b0;
    bit long_hold = 1'b0;

    int req_count  = 0;
    int res_count  = 0;
    int errors     = 0;
    int total_reqs = 0;

    // sender and receiver bookkeeping
    int send_wait  = 0;
    bit gap_loaded = 1'b0;
    bit offer      = 1'b0;
    int rcv_wait   = 0;

    multilabel_confusion_accumulator #(
        .NUM_CLASSES (CLASSES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .kind          (kind),
        .label_mask    (label_mask),
        .response_mask (response_mask),
        .read_row      (read_row),
        .read_col      (read_col),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .count_value   (count_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // reset is asserted once, from time zero, and released at a falling edge
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ------------------------------------------------------------------
    // matrix model
    // ------------------------------------------------------------------

    // bump entry (i, j) for label i and response j when i == j or label j is clear;
    // classes past the mask width have no bit and never count
    function automatic void apply_sample(input logic [MASK_WIDTH-1:0] labels,
                                         input logic [MASK_WIDTH-1:0] preds);
        int pos;
        for (int i = 0; i < CLASSES; i++)
        begin
            for (int j = 0; j < CLASSES; j++)
            begin
                pos = i * CLASSES + j;
                if (i < MASK_WIDTH && j < MASK_WIDTH && labels[i] && preds[j] &&
                    (i == j || !labels[j]) && conf_model[pos] != '1)
                    conf_model[pos] = conf_model[pos] + 1'b1;
            end
        end
    endfunction

    // advance the model by one accepted request, queueing the value a read returns
    function automatic void model_request(input sample_req_t r);
        logic [COUNT_W-1:0] value;
        case (r.kind)
            KIND_ACC:
                apply_sample(r.labels, r.preds);
            KIND_READ:
            begin
                // an address outside the matrix reads as zero
                value = '0;
                if (int'(r.row) < CLASSES && int'(r.col) < CLASSES)
                    value = conf_model[int'(r.row) * CLASSES + int'(r.col)];
                expected_counts.insert(expected_counts.size(), value);
            end
            KIND_CLEAR:
                foreach (conf_model[c])
                    conf_model[c] = '0;
            default:
                ;   // undefined kind leaves the matrix alone
        endcase
    endfunction

    initial
    begin
        foreach (conf_model[c])
            conf_model[c] = '0;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    function automatic void push_req(input logic [KIND_W-1:0] k,
                                     input logic [MASK_WIDTH-1:0] labels,
                                     input logic [MASK_WIDTH-1:0] preds,
                                     input logic [IDX_W-1:0] row,
                                     input logic [IDX_W-1:0] col,
                                     input int gap,
                                     input bit drain);
        sample_req_t r;
        r.kind   = k;
        r.labels = labels;
        r.preds  = preds;
        r.row    = row;
        r.col    = col;
        r.gap    = gap;
        r.drain  = drain;
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    // masks lean toward empty, full, one-hot and one-cold patterns
    function automatic logic [MASK_WIDTH-1:0] pick_mask();
        logic [MASK_WIDTH-1:0] one_hot;
        one_hot = MASK_WIDTH'(1) << $urandom_range(0, MASK_WIDTH - 1);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return MASK_WIDTH'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        int          pick;
        logic [KIND_W-1:0] k;
        int          gap;

        // directed part: empty matrix, full masks, one-hot rows, kind 3, clear
        push_req(KIND_READ,  8'h00, 8'h00, 3'd0, 3'd0, 0, 1'b0);
        push_req(KIND_ACC,   8'hff, 8'hff, 3'd0, 3'd0, 0, 1'b0);   // diagonal only
        push_req(KIND_READ,  8'h00, 8'h00, 3'd0, 3'd0, 0, 1'b0);
        push_req(KIND_READ,  8'h00, 8'h00, 3'd7, 3'd7, 0, 1'b0);
        push_req(KIND_READ,  8'h00, 8'h00, 3'd3, 3'd5, 0, 1'b0);
        push_req(KIND_ACC,   8'h01, 8'hfe, 3'd0, 3'd0, 2, 1'b0);   // row 0, all off-diagonal
        push_req(KIND_READ,  8'h00, 8'h00, 3'd0, 3'd7, 0, 1'b0);
        push_req(KIND_ACC,   8'h00, 8'hff, 3'd7, 3'd7, 0, 1'b0);   // no labels, nothing counts
        push_req(KIND_ACC,   8'h80, 8'h00, 3'd0, 3'd0, 0, 1'b0);   // no responses
        push_req(KIND_ACC,   8'h80, 8'h80, 3'd0, 3'd0, 0, 1'b0);
        push_req(KIND_NONE,  8'hff, 8'hff, 3'd7, 3'd7, 1, 1'b0);   // dropped
        push_req(KIND_READ,  8'h00, 8'h00, 3'd7, 3'd7, 0, 1'b0);
        push_req(KIND_ACC,   8'haa, 8'h55, 3'd0, 3'd0, 0, 1'b0);
        push_req(KIND_ACC,   8'haa, 8'hff, 3'd0, 3'd0, 0, 1'b0);   // label j set blocks (i, j)
        push_req(KIND_READ,  8'h00, 8'h00, 3'd1, 3'd0, 0, 1'b0);
        push_req(KIND_READ,  8'h00, 8'h00, 3'd1, 3'd3, 0, 1'b0);
        push_req(KIND_READ,  8'h00, 8'h00, 3'd3, 3'd3, 3, 1'b0);
        push_req(KIND_READ,  8'h00, 8'h00, 3'd6, 3'd7, 0, 1'b0);
        push_req(KIND_CLEAR, 8'hff, 8'hff, 3'd7, 3'd7, 0, 1'b0);
        push_req(KIND_READ,  8'h00, 8'h00, 3'd0, 3'd0, 0, 1'b0);
        push_req(KIND_READ,  8'h00, 8'h00, 3'd7, 3'd7, 0, 1'b0);
        push_req(KIND_ACC,   8'h7f, 8'h80, 3'd0, 3'd0, 0, 1'b0);
        push_req(KIND_READ,  8'h00, 8'h00, 3'd6, 3'd7, 0, 1'b0);

        // random part: mostly samples and reads, now and then a clear or a dropped kind
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                k = KIND_ACC;
            else if (pick < 92)
                k = KIND_READ;
            else if (pick < 96)
                k = KIND_CLEAR;
            else
                k = KIND_NONE;
            // every fourth stretch of 150 requests runs without sender gaps
            gap = ((n / 150) % 4 == 2) ? 0 : $urandom_range(0, 10);
            push_req(k, pick_mask(), pick_mask(),
                     IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                     gap, n == 0 || n == 700);
        end
        total_reqs = pending_reqs.size();

        while (req_count < total_reqs)
            @(negedge clk);
        while (expected_counts.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // request driver: payload and valid change at the falling edge
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!(req_valid && !req_taken))
        begin
            // nothing on the bus, or the last request went in at the rising edge
            offer = 1'b0;
            if (pending_reqs.size() != 0)
            begin
                if (!gap_loaded)
                begin
                    send_wait  = pending_reqs[0].gap;
                    gap_loaded = 1'b1;
                end
                if (pending_reqs[0].drain && expected_counts.size() != 0)
                    offer = 1'b0;   // hold until every read has been answered
                else if (send_wait != 0)
                    send_wait = send_wait - 1;
                else
                begin
                    on_bus        = pending_reqs.pop_front();
                    gap_loaded    = 1'b0;
                    offer         = 1'b1;
                    kind          <= on_bus.kind;
                    label_mask    <= on_bus.labels;
                    response_mask <= on_bus.preds;
                    read_row      <= on_bus.row;
                    read_col      <= on_bus.col;
                end
            end
            req_valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // result receiver: random stall per result, quiet stretches, one long hold
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (res_taken)
                rcv_wait = ((res_count / 40) % 4 == 2) ? 0 : $urandom_range(0, 10);
            if (long_hold)
                res_ready <= 1'b0;
            else if (rcv_wait != 0)
            begin
                rcv_wait = rcv_wait - 1;
                res_ready <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    // long result stall while requests keep coming, so the command queue fills
    // and req_ready has to drop
    initial
    begin
        while (req_count < HOLD_START)
            @(negedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // monitor: handshakes at the rising edge, results checked in order
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        req_taken = rst_n && req_valid && req_ready;
        res_taken = rst_n && res_valid && res_ready;

        // a result always belongs to an older read, so check before predicting
        if (res_taken)
        begin
            res_count = res_count + 1;
            if (expected_counts.size() == 0)
            begin
                errors = errors + 1;
                if (errors <= MAX_SHOWN)
                    $display("%0t: count result %0d with no read waiting", $time, count_value);
            end
            else if (count_value !== expected_counts[0])
            begin
                errors = errors + 1;
                if (errors <= MAX_SHOWN)
                    $display("%0t: count_value expected %0d got %0d",
                             $time, expected_counts[0], count_value);
                void'(expected_counts.pop_front());
            end
            else
                void'(expected_counts.pop_front());
        end

        if (req_taken)
        begin
            req_count = req_count + 1;
            model_request(on_bus);
        end
    end

    // hard stop well beyond the slowest correct run
    initial
    begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
